FILE: src/thick_line_disc_brush_raster_unit_macros.svh
// ----------------------------------------------------------------------------
// thick line rasterizer assertion macros
// shared concurrent assertion forms, clocked on clk and held off during arst_n
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_DISC_BRUSH_RASTER_UNIT_MACROS_SVH
`define THICK_LINE_DISC_BRUSH_RASTER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TLB_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlb assertion failed");

// consequent must hold in the cycle after the antecedent
`define TLB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlb assertion failed");

`endif

FILE: src/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// shared types and constants of the thick line rasterizer
// ----------------------------------------------------------------------------
package tlb_pkg;

	localparam int PIX_BITS       = 12;
	localparam int SIZE_BITS      = 13;
	localparam int RADIUS_BITS    = 6;
	localparam int COLOR_BITS     = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [SIZE_BITS-1:0]   CANVAS_LIMIT  = 13'd4096;
	localparam logic [SIZE_BITS-1:0]   WIDTH_RESET   = 13'd1024;
	localparam logic [SIZE_BITS-1:0]   HEIGHT_RESET  = 13'd1024;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET  = 6'd5;
	localparam logic [COLOR_BITS-1:0]  COLOR_RESET   = 32'd0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CANVAS_WIDTH  = 2'd0,
		REG_CANVAS_HEIGHT = 2'd1,
		REG_BRUSH_RADIUS  = 2'd2,
		REG_BRUSH_COLOR   = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_OUT  = 2'd2
	} state_t;

	typedef struct packed {
		logic take_tick;
		logic take_load;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

endpackage

FILE: src/tlb_channels.sv
// ----------------------------------------------------------------------------
// tlb channels
// valid/ready channels for segment commands, pixel results and register writes
// ----------------------------------------------------------------------------
interface tlb_cmd_if #(parameter int CoordBits = 13) ();
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic signed [CoordBits-1:0] start_x;
	logic signed [CoordBits-1:0] start_y;
	logic signed [CoordBits-1:0] end_x;
	logic signed [CoordBits-1:0] end_y;

	modport source(output valid, op, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlb_pix_if import tlb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [PIX_BITS-1:0]   pixel_x;
	logic [PIX_BITS-1:0]   pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  busy_res;

	modport source(output valid, write_enable, pixel_x, pixel_y, pixel_color, busy_res,
		input ready);
	modport sink(input valid, write_enable, pixel_x, pixel_y, pixel_color, busy_res,
		output ready);
endinterface

interface tlb_cfg_if import tlb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/tlb_div.sv
// ----------------------------------------------------------------------------
// tlb_div
// restoring divider, one quotient bit per cycle, for the fixed point slope
// ----------------------------------------------------------------------------
module tlb_div #(
	parameter int NumBits  = 13,
	parameter int FracBits = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NumBits-1:0]  dividend,
	input  logic [NumBits-1:0]  divisor,
	output logic                done,
	output logic [FracBits:0]   quotient
);

	localparam int CntBits = $clog2(FracBits + 1);

	logic               busy_q;
	logic               done_q;
	logic [CntBits-1:0] cnt_q;
	logic [NumBits:0]   rem_q;
	logic [NumBits-1:0] div_q;
	logic [FracBits:0]  quot_q;

	logic               ge;
	logic [NumBits:0]   diff;

	// the remainder shifts left each step, and the quotient register holds FracBits+1 bits
	always_comb begin
		ge   = rem_q >= {1'b0, div_q};
		diff = ge ? rem_q - {1'b0, div_q} : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(FracBits);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= {diff[NumBits-1:0], 1'b0};
			quot_q <= {quot_q[FracBits-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: src/tlb_datapath.sv
// ----------------------------------------------------------------------------
// tlb_datapath
// segment state, brush stepping, pixel arithmetic, clamping and result register
// ----------------------------------------------------------------------------
module tlb_datapath import tlb_pkg::*; #(
	parameter int CoordBits = 13,
	parameter int FracBits  = 16,
	parameter int MaxRadius = 50
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_status_t                  status,
	input  logic                        cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data,
	input  logic signed [CoordBits-1:0] start_x,
	input  logic signed [CoordBits-1:0] start_y,
	input  logic signed [CoordBits-1:0] end_x,
	input  logic signed [CoordBits-1:0] end_y,
	output logic                        write_enable,
	output logic [PIX_BITS-1:0]         pixel_x,
	output logic [PIX_BITS-1:0]         pixel_y,
	output logic [COLOR_BITS-1:0]       pixel_color,
	output logic                        busy_res
);

	localparam int C         = CoordBits;
	localparam int RadBits   = $clog2(MaxRadius + 1);
	localparam int OffBits   = RadBits + 1;
	localparam int SlopeBits = FracBits + 2;
	localparam int ProdBits  = SlopeBits + C + 1;
	localparam int AccBits   = ProdBits + 1;
	localparam int MinorBits = AccBits - FracBits;
	localparam int CmpBits   = (MinorBits > SIZE_BITS ? MinorBits : SIZE_BITS) + 1;

	localparam logic signed [OffBits:0] OFF_ONE = 1;
	localparam logic signed [C:0]       POS_ONE = 1;

	// configuration registers
	logic [SIZE_BITS-1:0]   canvas_w_q;
	logic [SIZE_BITS-1:0]   canvas_h_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [COLOR_BITS-1:0]  color_q;

	// segment state
	logic                        major_is_y_q;
	logic signed [C-1:0]         major_pos_q;
	logic signed [C-1:0]         major_end_q;
	logic signed [C-1:0]         major_start_q;
	logic signed [C-1:0]         minor_start_q;
	logic signed [SlopeBits-1:0] slope_q;
	logic signed [OffBits-1:0]   off_i_q;
	logic signed [OffBits-1:0]   off_j_q;
	logic                        active_q;
	logic                        neg_q;

	// first stage of a candidate
	logic signed [ProdBits-1:0] prod_s1;
	logic signed [C:0]          base_s1;
	logic signed [C:0]          majoff_s1;
	logic                       y_s1;
	logic                       draw_s1;
	logic                       busy_s1;
	logic                       load_s1;

	// result register
	logic                  we_q;
	logic [PIX_BITS-1:0]   px_q;
	logic [PIX_BITS-1:0]   py_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic                  busy_q;

	logic                  div_done;
	logic [FracBits:0]     quotient;

	// live radius
	logic [RadBits-1:0]        r_eff;
	logic signed [OffBits-1:0] r_neg;
	logic signed [OffBits:0]   r_cmp;

	always_comb begin
		r_eff = (radius_q > RADIUS_BITS'(MaxRadius)) ? RadBits'(MaxRadius)
			: radius_q[RadBits-1:0];
		r_neg = -$signed({1'b0, r_eff});
		r_cmp = $signed({2'b00, r_eff});
	end

	// segment setup
	logic signed [C:0]   dx, dy, dmaj, dmin;
	logic [C:0]          adx, ady, amin;
	logic                y_major, swap;
	logic signed [C-1:0] m0, m1, n0, n1, lo_m, hi_m, lo_n, hi_n;
	logic                seg_live;

	always_comb begin
		dx      = {end_x[C-1], end_x} - {start_x[C-1], start_x};
		dy      = {end_y[C-1], end_y} - {start_y[C-1], start_y};
		adx     = dx[C] ? -dx : dx;
		ady     = dy[C] ? -dy : dy;
		y_major = ady > adx;
		m0      = y_major ? start_y : start_x;
		m1      = y_major ? end_y : end_x;
		n0      = y_major ? start_x : start_y;
		n1      = y_major ? end_x : end_y;
		swap    = m0 > m1;
		lo_m    = swap ? m1 : m0;
		hi_m    = swap ? m0 : m1;
		lo_n    = swap ? n1 : n0;
		hi_n    = swap ? n0 : n1;
		dmaj    = {hi_m[C-1], hi_m} - {lo_m[C-1], lo_m};
		dmin    = {hi_n[C-1], hi_n} - {lo_n[C-1], lo_n};
		amin    = dmin[C] ? -dmin : dmin;
		seg_live = hi_m != lo_m;
	end

	tlb_div #(
		.NumBits (C),
		.FracBits(FracBits)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.take_load),
		.dividend(amin[C-1:0]),
		.divisor (dmaj[C-1:0]),
		.done    (div_done),
		.quotient(quotient)
	);

	assign status.div_done = div_done;

	// candidate arithmetic
	logic signed [C:0]           pos_delta;
	logic signed [ProdBits-1:0]  prod;
	logic signed [2*OffBits-1:0] ii, jj;
	logic [2*OffBits:0]          sq;
	logic [2*RadBits-1:0]        rr;
	logic signed [OffBits-1:0]   off_minor, off_major;
	logic signed [C:0]           base, majoff;
	logic signed [OffBits:0]     j_next, i_next;
	logic signed [C:0]           pos_next;
	logic                        wrap_j, wrap_i, seg_end;
	logic signed [SlopeBits-1:0] q_s;

	always_comb begin
		pos_delta = {major_pos_q[C-1], major_pos_q} - {major_start_q[C-1], major_start_q};
		prod      = slope_q * pos_delta;
		ii        = off_i_q * off_i_q;
		jj        = off_j_q * off_j_q;
		sq        = {1'b0, ii} + {1'b0, jj};
		rr        = r_eff * r_eff;
		off_minor = major_is_y_q ? off_i_q : off_j_q;
		off_major = major_is_y_q ? off_j_q : off_i_q;
		base      = {minor_start_q[C-1], minor_start_q}
			+ {{(C+1-OffBits){off_minor[OffBits-1]}}, off_minor};
		majoff    = {major_pos_q[C-1], major_pos_q}
			+ {{(C+1-OffBits){off_major[OffBits-1]}}, off_major};
		j_next    = {off_j_q[OffBits-1], off_j_q} + OFF_ONE;
		i_next    = {off_i_q[OffBits-1], off_i_q} + OFF_ONE;
		pos_next  = {major_pos_q[C-1], major_pos_q} + POS_ONE;
		wrap_j    = j_next > r_cmp;
		wrap_i    = i_next > r_cmp;
		seg_end   = wrap_j && wrap_i
			&& (pos_next >= $signed({major_end_q[C-1], major_end_q}));
		q_s       = $signed({1'b0, quotient});
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= WIDTH_RESET;
			canvas_h_q <= HEIGHT_RESET;
			radius_q   <= RADIUS_RESET;
			color_q    <= COLOR_RESET;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data[SIZE_BITS-1:0];
				REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data[SIZE_BITS-1:0];
				REG_BRUSH_RADIUS:  radius_q   <= cfg_data[RADIUS_BITS-1:0];
				REG_BRUSH_COLOR:   color_q    <= cfg_data[COLOR_BITS-1:0];
			endcase
		end
	end

	// segment state and brush stepping: j fastest, then i, then major position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_is_y_q  <= 1'b0;
			major_pos_q   <= '0;
			major_end_q   <= '0;
			major_start_q <= '0;
			minor_start_q <= '0;
			slope_q       <= '0;
			off_i_q       <= '0;
			off_j_q       <= '0;
			active_q      <= 1'b0;
			neg_q         <= 1'b0;
		end else if (cmd.take_load) begin
			major_is_y_q  <= y_major;
			major_pos_q   <= lo_m;
			major_end_q   <= hi_m;
			major_start_q <= lo_m;
			minor_start_q <= lo_n;
			slope_q       <= '0;
			off_i_q       <= r_neg;
			off_j_q       <= r_neg;
			active_q      <= seg_live;
			neg_q         <= dmin[C];
		end else if (div_done) begin
			if (!active_q) begin
				slope_q <= '0;
			end else begin
				slope_q <= neg_q ? -q_s : q_s;
			end
		end else if (cmd.take_tick && active_q) begin
			if (!wrap_j) begin
				off_j_q <= j_next[OffBits-1:0];
			end else begin
				off_j_q <= r_neg;
				if (!wrap_i) begin
					off_i_q <= i_next[OffBits-1:0];
				end else begin
					off_i_q     <= r_neg;
					major_pos_q <= pos_next[C-1:0];
					if (seg_end) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_load) begin
			load_s1 <= 1'b1;
			draw_s1 <= 1'b0;
			busy_s1 <= seg_live;
		end else if (cmd.take_tick) begin
			load_s1   <= 1'b0;
			draw_s1   <= active_q && (sq < {3'b000, rr});
			busy_s1   <= active_q && !seg_end;
			prod_s1   <= prod;
			base_s1   <= base;
			majoff_s1 <= majoff;
			y_s1      <= major_is_y_q;
		end
	end

	// second stage: fold in the minor base, truncate toward zero, clamp
	logic signed [AccBits-1:0]   acc;
	logic signed [MinorBits-1:0] minor_fl, minor, majoff_w, px_v, py_v;
	logic                        round_up;

	always_comb begin
		acc      = {{(AccBits-ProdBits){prod_s1[ProdBits-1]}}, prod_s1}
			+ {{(AccBits-C-1-FracBits){base_s1[C]}}, base_s1, {FracBits{1'b0}}};
		minor_fl = acc[AccBits-1:FracBits];
		round_up = acc[AccBits-1] && (|acc[FracBits-1:0]);
		minor    = minor_fl + $signed({{(MinorBits-1){1'b0}}, round_up});
		majoff_w = {{(MinorBits-C-1){majoff_s1[C]}}, majoff_s1};
		px_v     = y_s1 ? minor : majoff_w;
		py_v     = y_s1 ? majoff_w : minor;
	end

	function automatic logic [PIX_BITS-1:0] clamp_coord(
		input logic signed [MinorBits-1:0] v,
		input logic [SIZE_BITS-1:0]        size
	);
		logic [SIZE_BITS-1:0]      eff;
		logic [SIZE_BITS-1:0]      top;
		logic signed [CmpBits-1:0] v_w;
		logic signed [CmpBits-1:0] top_w;
		if (size == '0) begin
			eff = SIZE_BITS'(1);
		end else if (size > CANVAS_LIMIT) begin
			eff = CANVAS_LIMIT;
		end else begin
			eff = size;
		end
		top   = eff - 1'b1;
		v_w   = {{(CmpBits-MinorBits){v[MinorBits-1]}}, v};
		top_w = $signed({{(CmpBits-SIZE_BITS){1'b0}}, top});
		if (v_w[CmpBits-1]) begin
			return '0;
		end else if (v_w > top_w) begin
			return top[PIX_BITS-1:0];
		end
		return v_w[PIX_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			we_q   <= draw_s1 && !load_s1;
			busy_q <= busy_s1;
			if (draw_s1 && !load_s1) begin
				px_q        <= clamp_coord(px_v, canvas_w_q);
				py_q        <= clamp_coord(py_v, canvas_h_q);
				out_color_q <= color_q;
			end else begin
				px_q        <= '0;
				py_q        <= '0;
				out_color_q <= '0;
			end
		end
	end

	assign write_enable = we_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign pixel_color  = out_color_q;
	assign busy_res     = busy_q;

endmodule

FILE: src/tlb_ctrl.sv
// ----------------------------------------------------------------------------
// tlb_ctrl
// sequencer: accepts one word, waits out the slope divider on a load, hands off the result
// ----------------------------------------------------------------------------
`include "thick_line_disc_brush_raster_unit_macros.svh"

module tlb_ctrl import tlb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t st_q;
	state_t st_d;
	logic   out_valid_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = (in_op == OP_LOAD) ? ST_DIV : ST_OUT;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = st_q == ST_IDLE;
		cmd.take_tick = in_ready && in_valid && (in_op == OP_TICK);
		cmd.take_load = in_ready && in_valid && (in_op == OP_LOAD);
		// result register is free once the previous word leaves
		cmd.out_load  = (st_q == ST_OUT) && (!out_valid_q || out_ready);
		out_valid     = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TLB_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, st_q != ST_IDLE)
	`TLB_ASSERT_NOW(a_div_done_in_div, status.div_done, st_q == ST_DIV)
	`TLB_ASSERT_NEXT(a_result_held, (st_q == ST_OUT) && out_valid_q && !out_ready, st_q == ST_OUT)

endmodule

FILE: src/thick_line_disc_brush_raster_unit.sv
// tick word: the candidate passes through the first stage into the result register, and
// the next word is taken once it is there; load word: the result waits for the bit-serial slope
// divider (one quotient bit per cycle), and the next word is taken once that result is in the register
// one word in flight; the result register lets the next word in while a result waits
// reset (arst_n low, asynchronous): no segment loaded, configuration registers at their reset values
// ----------------------------------------------------------------------------
// thick_line_disc_brush_raster_unit
// line rasterizer with a round brush, one candidate pixel per tick word
// ----------------------------------------------------------------------------
module thick_line_disc_brush_raster_unit import tlb_pkg::*; #(
	parameter int COORD_BITS = 13,
	parameter int FRAC_BITS  = 16,
	parameter int MAX_RADIUS = 50
) (
	input  logic      clk,
	input  logic      arst_n,
	tlb_cmd_if.sink   cmd,
	tlb_pix_if.source pix,
	tlb_cfg_if.sink   cfg
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	assign cfg.ready = 1'b1;

	tlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_op    (cmd.op),
		.in_ready (cmd.ready),
		.out_valid(pix.valid),
		.out_ready(pix.ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	tlb_datapath #(
		.CoordBits(COORD_BITS),
		.FracBits (FRAC_BITS),
		.MaxRadius(MAX_RADIUS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.cfg_write   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.start_x     (cmd.start_x),
		.start_y     (cmd.start_y),
		.end_x       (cmd.end_x),
		.end_y       (cmd.end_y),
		.write_enable(pix.write_enable),
		.pixel_x     (pix.pixel_x),
		.pixel_y     (pix.pixel_y),
		.pixel_color (pix.pixel_color),
		.busy_res    (pix.busy_res)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick line rasterizer testbench
// feeds segment loads and brush ticks with random idling on both channels,
// predicts every pixel word and checks it field by field as it leaves the unit
// ----------------------------------------------------------------------------
module testbench import tlb_pkg::*; ();

	localparam int COORD_BITS   = 13;
	localparam int FRAC_BITS    = 16;
	localparam int MAX_RADIUS   = 50;
	localparam int TARGET_WORDS = 1050;
	localparam int PHASE_WORDS  = 85;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int LONG_HOLD    = 300;
	localparam int PRINT_LIMIT  = 30;
	localparam int TICK_CAP     = 250;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} seg_word_t;

	typedef struct packed {
		logic                  write_enable;
		logic [PIX_BITS-1:0]   pixel_x;
		logic [PIX_BITS-1:0]   pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  busy_res;
	} pixel_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlb_cmd_if #(.CoordBits(COORD_BITS)) cmd ();
	tlb_pix_if pix ();
	tlb_cfg_if cfg ();

	thick_line_disc_brush_raster_unit #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS),
		.MAX_RADIUS(MAX_RADIUS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.pix(pix),
		.cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expected pixel words
	seg_word_t   cmd_words[$];
	pixel_word_t pending_pixels[$];
	seg_word_t   cur_word = '0;
	int          words_queued = 0;
	int          errors = 0;

	// handshake flags, set at the rising edge and consumed at the falling edge
	bit cmd_taken = 1'b0;
	bit pix_taken = 1'b0;
	bit cmd_live = 1'b0;
	int cmd_gap = 0;
	int pix_gap = 0;
	bit src_calm = 1'b0;
	bit snk_calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// predicted register file and segment walker
	logic [SIZE_BITS-1:0]         canvas_w;
	logic [SIZE_BITS-1:0]         canvas_h;
	logic [RADIUS_BITS-1:0]       radius;
	logic [COLOR_BITS-1:0]        color;
	logic                         y_major;
	logic                         seg_busy;
	logic signed [COORD_BITS-1:0] pos;
	logic signed [COORD_BITS-1:0] pos_end;
	logic signed [COORD_BITS-1:0] pos_first;
	logic signed [COORD_BITS-1:0] minor_first;
	logic signed [29:0]           slope;
	logic signed [6:0]            off_i;
	logic signed [6:0]            off_j;

	function automatic longint live_radius();
		longint r;
		r = radius;
		return (r > MAX_RADIUS) ? MAX_RADIUS : r;
	endfunction

	function automatic longint canvas_span(logic [SIZE_BITS-1:0] size);
		longint s;
		s = size;
		if (s == 0) s = 1;
		if (s > 4096) s = 4096;
		return s;
	endfunction

	function automatic logic [PIX_BITS-1:0] clamp_pix(longint v, logic [SIZE_BITS-1:0] size);
		longint lim;
		lim = canvas_span(size);
		if (v < 0) return '0;
		if (v >= lim) return PIX_BITS'(lim - 1);
		return PIX_BITS'(v);
	endfunction

	function automatic pixel_word_t raster_step(seg_word_t w);
		pixel_word_t res;
		longint x0, y0, x1, y1, dx, dy, m0, m1, n0, n1, tmp;
		longint r, oi, oj, acc, minor, px, py, mp;
		res = '0;
		r = live_radius();
		if (w.op == OP_LOAD) begin
			x0 = $signed(w.start_x);
			y0 = $signed(w.start_y);
			x1 = $signed(w.end_x);
			y1 = $signed(w.end_y);
			dx = (x1 > x0) ? x1 - x0 : x0 - x1;
			dy = (y1 > y0) ? y1 - y0 : y0 - y1;
			y_major = dy > dx;
			if (y_major) begin
				m0 = y0; m1 = y1; n0 = x0; n1 = x1;
			end else begin
				m0 = x0; m1 = x1; n0 = y0; n1 = y1;
			end
			if (m0 > m1) begin
				tmp = m0; m0 = m1; m1 = tmp;
				tmp = n0; n0 = n1; n1 = tmp;
			end
			pos_first = COORD_BITS'(m0);
			pos_end = COORD_BITS'(m1);
			pos = COORD_BITS'(m0);
			minor_first = COORD_BITS'(n0);
			off_i = 7'(-r);
			off_j = 7'(-r);
			if (m1 == m0) begin
				slope = '0;
				seg_busy = 1'b0;
			end else begin
				slope = 30'(((n1 - n0) * (longint'(1) << FRAC_BITS)) / (m1 - m0));
				seg_busy = 1'b1;
			end
		end else if (seg_busy) begin
			oi = off_i;
			oj = off_j;
			mp = pos;
			if (oi * oi + oj * oj < r * r) begin
				acc = longint'(slope) * (mp - longint'(pos_first))
					+ (longint'(minor_first) + (y_major ? oi : oj)) * (longint'(1) << FRAC_BITS);
				minor = acc / (longint'(1) << FRAC_BITS);
				if (y_major) begin
					px = minor;
					py = mp + oj;
				end else begin
					px = mp + oi;
					py = minor;
				end
				res.write_enable = 1'b1;
				res.pixel_x = clamp_pix(px, canvas_w);
				res.pixel_y = clamp_pix(py, canvas_h);
				res.pixel_color = color;
			end
			// j fastest, then i, then the major position
			oj++;
			if (oj > r) begin
				oj = -r;
				oi++;
				if (oi > r) begin
					oi = -r;
					pos = COORD_BITS'(mp + 1);
					if (pos >= pos_end) seg_busy = 1'b0;
				end
			end
			off_i = 7'(oi);
			off_j = 7'(oj);
		end
		res.busy_res = seg_busy;
		return res;
	endfunction

	task automatic report_error(string msg);
		if (errors < PRINT_LIMIT) $display("%0t ns  mismatch: %s", $time, msg);
		errors++;
	endtask

	// output check first, then prediction of the word taken at this edge
	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n) begin
			if (pix.valid && pix.ready) begin
				pix_taken = 1'b1;
				if (pending_pixels.size() == 0) begin
					report_error($sformatf("pixel word with none pending, x %0d y %0d",
						pix.pixel_x, pix.pixel_y));
				end else begin
					want = pending_pixels.pop_front();
					if (pix.write_enable !== want.write_enable)
						report_error($sformatf("write_enable got %0d expected %0d",
							pix.write_enable, want.write_enable));
					if (pix.pixel_x !== want.pixel_x)
						report_error($sformatf("pixel_x got %0d expected %0d",
							pix.pixel_x, want.pixel_x));
					if (pix.pixel_y !== want.pixel_y)
						report_error($sformatf("pixel_y got %0d expected %0d",
							pix.pixel_y, want.pixel_y));
					if (pix.pixel_color !== want.pixel_color)
						report_error($sformatf("pixel_color got %h expected %h",
							pix.pixel_color, want.pixel_color));
					if (pix.busy_res !== want.busy_res)
						report_error($sformatf("busy_res got %0d expected %0d",
							pix.busy_res, want.busy_res));
				end
			end
			if (cmd.valid && cmd.ready) begin
				cmd_taken = 1'b1;
				pending_pixels = {pending_pixels, raster_step(cur_word)};
			end
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken) begin
				cmd_taken = 1'b0;
				cmd_live = 1'b0;
				cmd_gap = src_calm ? 0 : $urandom_range(0, 8);
			end
			if (!cmd_live && cmd_words.size() > 0) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
				end else begin
					cur_word = cmd_words.pop_front();
					cmd_live = 1'b1;
				end
			end
			cmd.valid <= cmd_live;
			cmd.op <= cur_word.op;
			cmd.start_x <= cur_word.start_x;
			cmd.start_y <= cur_word.start_y;
			cmd.end_x <= cur_word.end_x;
			cmd.end_y <= cur_word.end_y;
		end
	end

	// pixel receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (pix_taken) begin
				pix_taken = 1'b0;
				pix_gap = snk_calm ? 0 : $urandom_range(0, 8);
			end
			if (hold_left > 0) begin
				hold_left--;
				pix.ready <= 1'b0;
			end else if (pix_gap > 0) begin
				pix_gap--;
				pix.ready <= 1'b0;
			end else begin
				pix.ready <= 1'b1;
			end
		end
	end

	int unsigned cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic longint clip_coord(longint v);
		if (v < -4096) return -4096;
		if (v > 4095) return 4095;
		return v;
	endfunction

	function automatic longint any_coord();
		longint v;
		v = $urandom_range(0, 8191);
		return v - 4096;
	endfunction

	// mostly around the canvas so that clamping on both sides gets exercised
	function automatic longint near_canvas(logic [SIZE_BITS-1:0] size);
		longint v;
		if ($urandom_range(0, 4) == 0) return any_coord();
		v = $urandom_range(0, 32'(canvas_span(size) + 15));
		return clip_coord(v - 8);
	endfunction

	task automatic queue_word(op_t op, longint sx, longint sy, longint ex, longint ey);
		seg_word_t w;
		w.op = op;
		w.start_x = COORD_BITS'(sx);
		w.start_y = COORD_BITS'(sy);
		w.end_x = COORD_BITS'(ex);
		w.end_y = COORD_BITS'(ey);
		cmd_words = {cmd_words, w};
		words_queued++;
	endtask

	// tick fields carry junk, the unit has to ignore them
	task automatic queue_ticks(int n);
		repeat (n) queue_word(OP_TICK, any_coord(), any_coord(), any_coord(), any_coord());
	endtask

	// short segment, then enough ticks to finish it, sometimes cut short by the next load
	task automatic queue_segment();
		longint sx, sy, ex, ey, len, dmaj, dmin, span, cand, r;
		bit ymaj;
		int n;
		r = live_radius();
		sx = near_canvas(canvas_w);
		sy = near_canvas(canvas_h);
		len = (r == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
		dmaj = len;
		dmin = $urandom_range(0, 32'(len));
		ymaj = $urandom_range(0, 1);
		if (ymaj && dmin == dmaj) dmin--;
		if ($urandom_range(0, 1)) dmaj = -dmaj;
		if ($urandom_range(0, 1)) dmin = -dmin;
		if (ymaj) begin
			ex = clip_coord(sx + dmin);
			ey = clip_coord(sy + dmaj);
		end else begin
			ex = clip_coord(sx + dmaj);
			ey = clip_coord(sy + dmin);
		end
		queue_word(OP_LOAD, sx, sy, ex, ey);
		span = (ex > sx) ? ex - sx : sx - ex;
		if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;
		cand = (2 * r + 1) * (2 * r + 1) * span;
		if (cand == 0)
			n = $urandom_range(1, 3);
		else if (cand > TICK_CAP)
			n = $urandom_range(150, TICK_CAP);
		else if ($urandom_range(0, 6) == 0)
			n = $urandom_range(1, 32'(cand));
		else
			n = int'(cand) + $urandom_range(0, 2);
		queue_ticks(n);
	endtask

	task automatic fill_phase(int n);
		int stop;
		stop = words_queued + n;
		if (stop > TARGET_WORDS) stop = TARGET_WORDS;
		while (words_queued < stop) begin
			if ($urandom_range(0, 9) < 8) begin
				queue_segment();
			end else if ($urandom_range(0, 2) == 0) begin
				queue_ticks($urandom_range(1, 4));
			end else begin
				queue_word(OP_LOAD, any_coord(), any_coord(), any_coord(), any_coord());
				queue_ticks($urandom_range(0, 20));
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (cmd_words.size() != 0 || cmd_live || pending_pixels.size() != 0);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk);
		while (!cfg.ready);
		case (idx)
			REG_CANVAS_WIDTH:  canvas_w = val[SIZE_BITS-1:0];
			REG_CANVAS_HEIGHT: canvas_h = val[SIZE_BITS-1:0];
			REG_BRUSH_RADIUS:  radius = val[RADIUS_BITS-1:0];
			REG_BRUSH_COLOR:   color = val[COLOR_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all(int w, int h, int r, logic [COLOR_BITS-1:0] c);
		write_reg(REG_CANVAS_WIDTH, CFG_DATA_BITS'(w));
		write_reg(REG_CANVAS_HEIGHT, CFG_DATA_BITS'(h));
		write_reg(REG_BRUSH_RADIUS, CFG_DATA_BITS'(r));
		write_reg(REG_BRUSH_COLOR, c);
	endtask

	function automatic int pick_radius();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return $urandom_range(1, 3);
		if (sel == 7) return 0;
		if (sel == 8) return $urandom_range(4, 6);
		return $urandom_range(40, 63);
	endfunction

	function automatic int pick_size();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 8191);
		return $urandom_range(1, 300);
	endfunction

	initial begin
		int phase;
		cmd.valid = 1'b0;
		cmd.op = OP_TICK;
		cmd.start_x = '0;
		cmd.start_y = '0;
		cmd.end_x = '0;
		cmd.end_y = '0;
		pix.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_CANVAS_WIDTH;
		cfg.data = '0;
		canvas_w = WIDTH_RESET;
		canvas_h = HEIGHT_RESET;
		radius = RADIUS_RESET;
		color = COLOR_RESET;
		y_major = 1'b0;
		seg_busy = 1'b0;
		pos = '0;
		pos_end = '0;
		pos_first = '0;
		minor_first = '0;
		slope = '0;
		off_i = '0;
		off_j = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: idle tick, a single-point segment, a full-range diagonal
		queue_word(OP_TICK, 0, 0, 0, 0);
		queue_word(OP_LOAD, 7, -9, 7, -9);
		queue_word(OP_TICK, 0, 0, 0, 0);
		queue_word(OP_LOAD, 4095, -4096, -4096, 4095);
		queue_ticks(6);
		drain();

		// small canvas: reversed steep segment replaced while busy, then a clamped one
		write_all(16, 16, 1, 32'hA5A5_5A5A);
		queue_word(OP_LOAD, 3, 11, 4, 9);
		queue_ticks(4);
		queue_word(OP_LOAD, 0, 17, -1, 16);
		queue_ticks(10);

		phase = 2;
		while (words_queued < TARGET_WORDS) begin
			drain();
			case (phase)
				2: write_all(1, 1, 2, 32'hFFFF_FFFF);
				3: write_all(4096, 4096, 0, 32'h0000_0000);
				4: write_all(0, 8191, 3, $urandom());
				5: write_all(8191, 0, 63, $urandom());
				6: write_all(200, 120, 1, $urandom());
				default: write_all(pick_size(), pick_size(), pick_radius(), $urandom());
			endcase
			src_calm = ($urandom_range(0, 3) == 0);
			snk_calm = ($urandom_range(0, 3) == 0);
			// receiver holds off while the sender keeps offering words
			if (phase == 3 || phase == 8) begin
				src_calm = 1'b1;
				hold_req = 1'b1;
			end
			fill_phase(PHASE_WORDS);
			phase++;
		end
		drain();
		repeat (FRAC_BITS + 8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/tlb_pkg.sv
src/tlb_channels.sv
src/tlb_div.sv
src/tlb_datapath.sv
src/tlb_ctrl.sv
src/thick_line_disc_brush_raster_unit.sv
tb/testbench.sv
